// ----- rtl/core/tlv_metadata_validator_defines.svh -----
// Assertion macros for the TLV metadata validator.
// Used by the top level; needs clk and arst_n in the including scope.
`ifndef TLV_METADATA_VALIDATOR_DEFINES_SVH
`define TLV_METADATA_VALIDATOR_DEFINES_SVH

// Same-cycle implication, off during reset.
`define TMV_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define TMV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tmv_pkg.sv -----
// Shared types and constants of the TLV metadata validator.
// No dependencies; imported by every module of the block.
package tmv_pkg;

	localparam logic [15:0] MAX_META_BYTES = 16'd4096;

	// Record types with fixed rules
	localparam logic [15:0] TLV_TYPE_NONE = 16'd0;
	localparam logic [15:0] TLV_TYPE_U32  = 16'd1;
	localparam logic [15:0] TLV_TYPE_U64  = 16'd2;
	localparam logic [15:0] TLV_TYPE_TEXT = 16'd3;
	localparam logic [15:0] TLV_TYPE_NAME = 16'd4;

	localparam logic [31:0] LEN_U32      = 32'd4;
	localparam logic [31:0] LEN_U64      = 32'd8;
	localparam logic [31:0] LEN_TEXT_MAX = 32'd1024;
	localparam logic [31:0] LEN_NAME_MAX = 32'd255;

	// UTF-8 lead byte ranges and code point limits
	localparam logic [7:0]  UTF_LEAD2_MIN = 8'hC2;
	localparam logic [7:0]  UTF_LEAD2_MAX = 8'hDF;
	localparam logic [7:0]  UTF_LEAD3_MIN = 8'hE0;
	localparam logic [7:0]  UTF_LEAD3_MAX = 8'hEF;
	localparam logic [7:0]  UTF_LEAD4_MIN = 8'hF0;
	localparam logic [7:0]  UTF_LEAD4_MAX = 8'hF4;
	localparam logic [20:0] UTF_MIN2      = 21'h80;
	localparam logic [20:0] UTF_MIN3      = 21'h800;
	localparam logic [20:0] UTF_MIN4      = 21'h10000;
	localparam logic [20:0] UTF_SURR_LO   = 21'hD800;
	localparam logic [20:0] UTF_SURR_HI   = 21'hDFFF;
	localparam logic [20:0] UTF_MAX       = 21'h10FFFF;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_VALUE  = 2'd1,
		PH_PAD    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_MALFORMED   = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  pend;
		logic [20:0] code;
		logic [7:0]  lead;
	} utf_state_t;

	typedef struct packed {
		status_t     code;
		logic [15:0] rec_type;
		logic [15:0] val_len;
	} hdr_result_t;

endpackage

// ----- rtl/core/tmv_utf8_step.sv -----
// One-byte step of the UTF-8 decoder for text record values.
// Depends on tmv_pkg.
module tmv_utf8_step
	import tmv_pkg::*;
(
	input  utf_state_t cur,
	input  logic [7:0] data,
	output utf_state_t nxt,
	output logic       err
);

	logic [20:0] code_sh;

	assign code_sh = {cur.code[14:0], data[5:0]};

	always_comb begin
		nxt = cur;
		err = 1'b0;
		if (cur.pend == 2'd0) begin
			if (data == 8'd0) begin
				err = 1'b1;
			end else if (data[7]) begin
				nxt.lead = data;
				if (data inside {[UTF_LEAD2_MIN:UTF_LEAD2_MAX]}) begin
					nxt.code = {16'd0, data[4:0]};
					nxt.pend = 2'd1;
				end else if (data inside {[UTF_LEAD3_MIN:UTF_LEAD3_MAX]}) begin
					nxt.code = {17'd0, data[3:0]};
					nxt.pend = 2'd2;
				end else if (data inside {[UTF_LEAD4_MIN:UTF_LEAD4_MAX]}) begin
					nxt.code = {18'd0, data[2:0]};
					nxt.pend = 2'd3;
				end else begin
					err = 1'b1;
				end
			end
		end else if (data[7:6] != 2'b10) begin
			err = 1'b1;
		end else begin
			nxt.code = code_sh;
			nxt.pend = cur.pend - 2'd1;
			// sequence complete: reject overlongs, surrogates, out of range
			if (cur.pend == 2'd1) begin
				if (code_sh < UTF_MIN2 ||
				    (code_sh < UTF_MIN3 && cur.lead >= UTF_LEAD3_MIN) ||
				    (code_sh < UTF_MIN4 && cur.lead >= UTF_LEAD4_MIN) ||
				    (code_sh >= UTF_SURR_LO && code_sh <= UTF_SURR_HI) ||
				    code_sh > UTF_MAX) begin
					err = 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/tmv_hdr_check.sv -----
// Record header checks: ordering, flags, length rules and fit in the blob.
// Depends on tmv_pkg.
module tmv_hdr_check
	import tmv_pkg::*;
(
	input  logic [63:0]  hdr,
	input  logic [15:0]  offset,
	input  logic [15:0]  total,
	input  logic [15:0]  prior_type,
	output hdr_result_t  res
);

	logic [15:0] rec_type;
	logic [15:0] flags;
	logic [31:0] length;
	logic [16:0] start;
	logic [15:0] remaining;
	logic [32:0] padded;
	logic        bad_len;

	assign rec_type = hdr[15:0];
	assign flags    = hdr[31:16];
	assign length   = hdr[63:32];
	// offset points at the last header byte; the record began seven earlier
	assign start    = {1'b0, offset} - 17'd7;
	assign remaining = (!start[16] && total > start[15:0]) ? (total - start[15:0]) : 16'd0;
	assign padded   = ({1'b0, length} + 33'd15) & ~33'd7;

	always_comb begin
		case (rec_type)
			TLV_TYPE_U32:  bad_len = (length != LEN_U32);
			TLV_TYPE_U64:  bad_len = (length != LEN_U64);
			TLV_TYPE_TEXT: bad_len = (length == 32'd0) || (length > LEN_TEXT_MAX);
			TLV_TYPE_NAME: bad_len = (length == 32'd0) || (length > LEN_NAME_MAX);
			default:       bad_len = 1'b0;
		endcase
	end

	always_comb begin
		res.rec_type = rec_type;
		res.val_len  = length[15:0];
		if (remaining < 16'd8) begin
			res.code = ST_MALFORMED;
		end else if (rec_type == TLV_TYPE_NONE || rec_type <= prior_type ||
		             flags[15:1] != 15'd0) begin
			res.code = ST_MALFORMED;
		end else if (length > {16'd0, remaining - 16'd8}) begin
			res.code = ST_MALFORMED;
		end else if (bad_len) begin
			res.code = ST_MALFORMED;
		end else if (rec_type > TLV_TYPE_NAME && flags[0]) begin
			res.code = ST_UNSUPPORTED;
		end else if (padded > {17'd0, remaining}) begin
			res.code = ST_MALFORMED;
		end else begin
			res.code = ST_OK;
		end
	end

endmodule

// ----- rtl/core/tlv_metadata_validator.sv -----
// TLV metadata validator, top level. Depends on tmv_pkg, tmv_utf8_step,
// tmv_hdr_check and tlv_metadata_validator_defines.svh.
//
// Input channel (s_*): one blob byte per transaction, s_tlast on the final
// byte; every transaction carries the declared blob length. A transaction
// with a length of zero and s_tlast set stands for an empty blob.
// Output channel (m_*): one status transaction per blob, issued for the
// transaction that carried s_tlast: ok, malformed, or unsupported critical
// record type. Transactions without s_tlast give no output.
// Throughput: one byte per clock. A byte enters an input register, is
// checked against the record state by combinational logic, and a status
// is written to the output register, which drives m_tvalid. The output
// register lets non-final bytes of the next blob flow while a status
// waits; only a final byte holds in the input register while the
// receiver stalls.
// Reset (arst_n low) empties both registers and returns the record state
// to the start of a blob; the state also returns there after each blob.
`include "tlv_metadata_validator_defines.svh"

module tlv_metadata_validator
	import tmv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] total_length
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [1:0] status, [7:2] zero
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [15:0] total_s1;

	// record state
	logic [15:0] offset_q;
	phase_t      phase_q;
	logic [15:0] cnt_q;
	logic [63:0] hdr_q;
	logic [15:0] prior_q;
	utf_state_t  utf_q;
	status_t     sticky_q;

	// output register
	logic        out_valid_q;
	status_t     status_q;

	// next state
	logic [15:0] offset_n;
	phase_t      phase_n;
	logic [15:0] cnt_n;
	logic [63:0] hdr_n;
	logic [15:0] prior_n;
	utf_state_t  utf_n;
	status_t     sticky_n;
	status_t     status_c;

	logic [63:0] hdr_cat;
	hdr_result_t hdr_res;
	utf_state_t  utf_step;
	logic        utf_err;
	logic        is_text;
	logic        out_free;
	logic        adv_s1;

	// Handshake: a final byte may leave the input register only when the
	// output register is free or being emptied; other bytes always advance.
	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, status_q};

	// Merge the incoming byte into its header lane
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hdr_cat[8*i +: 8] = hdr_q[8*i +: 8] |
				((cnt_q[2:0] == 3'(i)) ? byte_s1 : 8'd0);
		end
	end

	tmv_hdr_check u_hdr_check (
		.hdr        (hdr_cat),
		.offset     (offset_q),
		.total      (total_s1),
		.prior_type (prior_q),
		.res        (hdr_res)
	);

	tmv_utf8_step u_utf8_step (
		.cur  (utf_q),
		.data (byte_s1),
		.nxt  (utf_step),
		.err  (utf_err)
	);

	assign is_text = (hdr_q[15:0] == TLV_TYPE_TEXT) || (hdr_q[15:0] == TLV_TYPE_NAME);

	// Next record state for the byte in the input register
	always_comb begin
		logic [15:0] cnt_dec;
		logic [2:0]  pad;

		offset_n = offset_q;
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		hdr_n    = hdr_q;
		prior_n  = prior_q;
		utf_n    = utf_q;
		sticky_n = sticky_q;
		cnt_dec  = (cnt_q != 16'd0) ? (cnt_q - 16'd1) : 16'd0;
		pad      = 3'd0 - hdr_q[34:32];

		if (offset_q < total_s1) begin
			offset_n = offset_q + 16'd1;
			// once an error is kept, only the offset moves
			if (sticky_q == ST_OK) begin
				case (phase_q)
					PH_HEADER: begin
						hdr_n = hdr_cat;
						cnt_n = cnt_q + 16'd1;
						if (cnt_q[2:0] == 3'd7) begin
							if (hdr_res.code != ST_OK) begin
								sticky_n = hdr_res.code;
							end else begin
								prior_n = hdr_res.rec_type;
								utf_n   = '0;
								if (hdr_res.val_len != 16'd0) begin
									phase_n = PH_VALUE;
									cnt_n   = hdr_res.val_len;
								end else begin
									phase_n = PH_HEADER;
									cnt_n   = 16'd0;
									hdr_n   = '0;
								end
							end
						end
					end
					PH_VALUE: begin
						if (is_text && utf_err) begin
							sticky_n = ST_MALFORMED;
						end else begin
							if (is_text) begin
								utf_n = utf_step;
							end
							cnt_n = cnt_dec;
							if (cnt_dec == 16'd0) begin
								if (is_text && utf_step.pend != 2'd0) begin
									sticky_n = ST_MALFORMED;
								end else if (pad != 3'd0) begin
									phase_n = PH_PAD;
									cnt_n   = {13'd0, pad};
								end else begin
									phase_n = PH_HEADER;
									cnt_n   = 16'd0;
									hdr_n   = '0;
								end
							end
						end
					end
					default: begin
						// padding: zeros only
						if (byte_s1 != 8'd0) begin
							sticky_n = ST_MALFORMED;
						end else begin
							cnt_n = cnt_dec;
							if (cnt_dec == 16'd0) begin
								phase_n = PH_HEADER;
								cnt_n   = 16'd0;
								hdr_n   = '0;
							end
						end
					end
				endcase
			end
		end
	end

	// Blob status for a final byte
	always_comb begin
		if (total_s1 > MAX_META_BYTES) begin
			status_c = ST_MALFORMED;
		end else if (sticky_n != ST_OK) begin
			status_c = sticky_n;
		end else if (offset_n < total_s1) begin
			status_c = ST_MALFORMED;
		end else if (phase_n != PH_HEADER || cnt_n != 16'd0) begin
			status_c = ST_MALFORMED;
		end else begin
			status_c = ST_OK;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata[7:0];
			total_s1 <= s_tdata[23:8];
			last_s1  <= s_tlast;
		end
	end

	// Record state: advance per byte, clear after each blob
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			phase_q  <= PH_HEADER;
			cnt_q    <= '0;
			hdr_q    <= '0;
			prior_q  <= '0;
			utf_q    <= '0;
			sticky_q <= ST_OK;
		end else if (adv_s1) begin
			if (last_s1) begin
				offset_q <= '0;
				phase_q  <= PH_HEADER;
				cnt_q    <= '0;
				hdr_q    <= '0;
				prior_q  <= '0;
				utf_q    <= '0;
				sticky_q <= ST_OK;
			end else begin
				offset_q <= offset_n;
				phase_q  <= phase_n;
				cnt_q    <= cnt_n;
				hdr_q    <= hdr_n;
				prior_q  <= prior_n;
				utf_q    <= utf_n;
				sticky_q <= sticky_n;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			status_q <= status_c;
		end
	end

	`TMV_ASSERT_NEXT(a_blob_end_clears, adv_s1 && last_s1, offset_q == 16'd0 && sticky_q == ST_OK && phase_q == PH_HEADER, "state not cleared after final byte")
	`TMV_ASSERT_IMPL(a_status_from_final, $rose(m_tvalid), $past(adv_s1 && last_s1), "status issued without a final byte")
	`TMV_ASSERT_IMPL(a_pad_count_range, phase_q == PH_PAD && sticky_q == ST_OK, cnt_q != 16'd0 && cnt_q < 16'd8, "padding count out of range")
	`TMV_ASSERT_IMPL(a_utf_only_in_value, utf_q.pend != 2'd0 && sticky_q == ST_OK, phase_q == PH_VALUE, "UTF-8 sequence open outside a value")

endmodule

// ----- bench/tlv_status_checker.sv -----
// Scoreboard for the TLV metadata validator: watches both stream channels,
// predicts the status of every blob and compares it with the output channel.
// Depends on tmv_pkg for the status and phase types and the record limits.
module tlv_status_checker
	import tmv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] total_length
	input  logic        s_tlast,   // last_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [1:0] status, [7:2] zero
	output int          fail_count,
	output int          pending
);

	// Record-walk state of the blob in progress
	logic [15:0] offset;
	phase_t      phase;
	logic [31:0] count;
	logic [63:0] hdr;
	logic [15:0] last_type;
	logic [1:0]  utf_left;
	logic [20:0] utf_acc;
	logic [7:0]  utf_first;
	status_t     first_error;

	status_t     blob_status_q[$];

	function automatic void note_failure(string msg);
		if (fail_count < 10) begin
			$display("%0t: %s", $realtime, msg);
		end
		fail_count++;
	endfunction

	function automatic void note_error(status_t code);
		if (first_error == ST_OK) begin
			first_error = code;
		end
	endfunction

	function automatic void open_header();
		phase = PH_HEADER;
		count = '0;
		hdr   = '0;
	endfunction

	function automatic void clear_blob();
		offset      = '0;
		open_header();
		last_type   = '0;
		utf_left    = '0;
		utf_acc     = '0;
		utf_first   = '0;
		first_error = ST_OK;
	endfunction

	function automatic void utf_step(logic [7:0] b);
		if (utf_left == 2'd0) begin
			if (b == 8'h00) begin
				note_error(ST_MALFORMED);
			end else if (b[7]) begin
				utf_first = b;
				if (b >= UTF_LEAD2_MIN && b <= UTF_LEAD2_MAX) begin
					utf_acc  = {16'd0, b[4:0]};
					utf_left = 2'd1;
				end else if (b >= UTF_LEAD3_MIN && b <= UTF_LEAD3_MAX) begin
					utf_acc  = {17'd0, b[3:0]};
					utf_left = 2'd2;
				end else if (b >= UTF_LEAD4_MIN && b <= UTF_LEAD4_MAX) begin
					utf_acc  = {18'd0, b[2:0]};
					utf_left = 2'd3;
				end else begin
					note_error(ST_MALFORMED);
				end
			end
		end else if (b[7:6] != 2'b10) begin
			note_error(ST_MALFORMED);
		end else begin
			utf_acc  = {utf_acc[14:0], b[5:0]};
			utf_left = utf_left - 2'd1;
			// reject overlong forms, surrogates and anything past the last plane
			if (utf_left == 2'd0 &&
					(utf_acc < UTF_MIN2 ||
					(utf_acc < UTF_MIN3 && utf_first >= UTF_LEAD3_MIN) ||
					(utf_acc < UTF_MIN4 && utf_first >= UTF_LEAD4_MIN) ||
					(utf_acc >= UTF_SURR_LO && utf_acc <= UTF_SURR_HI) ||
					utf_acc > UTF_MAX)) begin
				note_error(ST_MALFORMED);
			end
		end
	endfunction

	function automatic void close_header(logic [15:0] total);
		logic [15:0] rtype;
		logic [15:0] rflags;
		logic [31:0] rlen;
		logic [31:0] start;
		logic [31:0] room;
		logic [32:0] padded;
		logic        bad_len;
		rtype   = hdr[15:0];
		rflags  = hdr[31:16];
		rlen    = hdr[63:32];
		start   = {16'd0, offset} - 32'd7;
		room    = ({16'd0, total} > start) ? {16'd0, total} - start : 32'd0;
		padded  = ({1'b0, rlen} + 33'd15) & ~33'd7;
		bad_len = 1'b0;
		if (room < 32'd8) begin
			note_error(ST_MALFORMED);
			return;
		end
		if (rtype == TLV_TYPE_NONE || rtype <= last_type || rflags[15:1] != '0) begin
			note_error(ST_MALFORMED);
			return;
		end
		if (rlen > room - 32'd8) begin
			note_error(ST_MALFORMED);
			return;
		end
		if (rtype == TLV_TYPE_U32) begin
			bad_len = (rlen != LEN_U32);
		end else if (rtype == TLV_TYPE_U64) begin
			bad_len = (rlen != LEN_U64);
		end else if (rtype == TLV_TYPE_TEXT) begin
			bad_len = (rlen == 32'd0 || rlen > LEN_TEXT_MAX);
		end else if (rtype == TLV_TYPE_NAME) begin
			bad_len = (rlen == 32'd0 || rlen > LEN_NAME_MAX);
		end else if (rflags[0]) begin
			note_error(ST_UNSUPPORTED);
			return;
		end
		if (bad_len || padded > {1'b0, room}) begin
			note_error(ST_MALFORMED);
			return;
		end
		last_type = rtype;
		utf_left  = '0;
		utf_acc   = '0;
		utf_first = '0;
		if (rlen != 32'd0) begin
			phase = PH_VALUE;
			count = rlen;
		end else begin
			open_header();
		end
	endfunction

	function automatic void close_value();
		logic [2:0] pad;
		pad = 3'd0 - hdr[34:32];
		if (utf_left != 2'd0) begin
			note_error(ST_MALFORMED);
			return;
		end
		if (pad != 3'd0) begin
			phase = PH_PAD;
			count = {29'd0, pad};
		end else begin
			open_header();
		end
	endfunction

	function automatic void walk_byte(logic [7:0] b, logic [15:0] total);
		logic [15:0] rtype;
		rtype = hdr[15:0];
		case (phase)
			PH_HEADER: begin
				hdr   = hdr | ({56'd0, b} << {count[2:0], 3'b000});
				count = count + 32'd1;
				if (count >= 32'd8) begin
					close_header(total);
				end
			end
			PH_VALUE: begin
				if (rtype == TLV_TYPE_TEXT || rtype == TLV_TYPE_NAME) begin
					utf_step(b);
				end
				if (first_error != ST_OK) begin
					return;
				end
				if (count != 32'd0) begin
					count = count - 32'd1;
				end
				if (count == 32'd0) begin
					close_value();
				end
			end
			default: begin
				// padding must be zero
				if (b != 8'h00) begin
					note_error(ST_MALFORMED);
					return;
				end
				if (count != 32'd0) begin
					count = count - 32'd1;
				end
				if (count == 32'd0) begin
					open_header();
				end
			end
		endcase
	endfunction

	// Advance the prediction by one input transaction; queue a status on the final byte.
	function automatic void absorb_byte(logic [7:0] b, logic final_byte, logic [15:0] total);
		status_t verdict;
		if (offset < total) begin
			if (first_error == ST_OK) begin
				walk_byte(b, total);
			end
			offset = offset + 16'd1;
		end
		if (final_byte) begin
			if (total > MAX_META_BYTES) begin
				verdict = ST_MALFORMED;
			end else if (first_error != ST_OK) begin
				verdict = first_error;
			end else if (offset < total) begin
				verdict = ST_MALFORMED;
			end else if (phase != PH_HEADER || count != 32'd0) begin
				verdict = ST_MALFORMED;
			end else begin
				verdict = ST_OK;
			end
			blob_status_q.push_back(verdict);
			clear_blob();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		status_t want;
		if (!arst_n) begin
			clear_blob();
			blob_status_q.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (blob_status_q.size() == 0) begin
					note_failure($sformatf("status with no blob pending: got 0x%02h", m_tdata));
				end else begin
					want = blob_status_q.pop_front();
					if (m_tdata != {6'd0, want}) begin
						note_failure($sformatf("status mismatch: expected 0x%02h, got 0x%02h",
							{6'd0, want}, m_tdata));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				absorb_byte(s_tdata[7:0], s_tlast, s_tdata[23:8]);
			end
			pending = blob_status_q.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the TLV metadata validator: builds metadata blobs,
// streams them byte by byte and gives the verdict from the checker's count.
// Depends on tmv_pkg, tlv_metadata_validator and tlv_status_checker.
module tb_top
	import tmv_pkg::*;
();

	localparam int RANDOM_ITEMS = 1350;
	localparam int MIN_BLOBS    = 12;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // [7:0] data_byte, [23:8] total_length
	logic        s_tlast  = 1'b0; // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [1:0] status, [7:2] zero

	int          fail_count;
	int          pending;
	int          items_sent = 0;
	logic        hold_off   = 1'b0;
	bit          calm_tx    = 1'b0;
	bit          calm_rx    = 1'b0;

	// Bytes of the blob being assembled
	logic [7:0]  blob_bytes[$];

	tlv_metadata_validator i_dut (
		.clk,
		.arst_n,
		.s_tvalid,
		.s_tready,
		.s_tdata,
		.s_tlast,
		.m_tvalid,
		.m_tready,
		.m_tdata
	);

	tlv_status_checker i_checker (
		.clk,
		.arst_n,
		.s_tvalid,
		.s_tready,
		.s_tdata,
		.s_tlast,
		.m_tvalid,
		.m_tready,
		.m_tdata,
		.fail_count,
		.pending
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Hard limit on the run
	initial begin
		#1000000;
		$display("Some tests failed");
		$finish;
	end

	// Append a little-endian field of count bytes.
	function automatic void put_le(logic [31:0] value, int count);
		for (int i = 0; i < count; i++) begin
			blob_bytes.push_back(value[8*i +: 8]);
		end
	endfunction

	// Append one well-formed UTF-8 character of the given encoded size,
	// often at the edge of that size's code point range.
	function automatic void put_char(int size);
		logic [20:0] cp;
		logic [20:0] lo;
		logic [20:0] hi;
		case (size)
			1: begin
				lo = 21'h01;
				hi = 21'h7F;
			end
			2: begin
				lo = 21'h80;
				hi = 21'h7FF;
			end
			3: begin
				// stay clear of the surrogate block
				if ($urandom_range(0, 1) != 0) begin
					lo = 21'h800;
					hi = 21'hD7FF;
				end else begin
					lo = 21'hE000;
					hi = 21'hFFFF;
				end
			end
			default: begin
				lo = 21'h10000;
				hi = 21'h10FFFF;
			end
		endcase
		case ($urandom_range(0, 7))
			0: cp = lo;
			1: cp = hi;
			default: cp = 21'($urandom_range(lo, hi));
		endcase
		case (size)
			1: blob_bytes.push_back({1'b0, cp[6:0]});
			2: begin
				blob_bytes.push_back({3'b110, cp[10:6]});
				blob_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				blob_bytes.push_back({4'b1110, cp[15:12]});
				blob_bytes.push_back({2'b10, cp[11:6]});
				blob_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				blob_bytes.push_back({5'b11110, cp[20:18]});
				blob_bytes.push_back({2'b10, cp[17:12]});
				blob_bytes.push_back({2'b10, cp[11:6]});
				blob_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// Append a broken UTF-8 sequence, cut to fit; return the bytes used.
	function automatic int put_bad_utf(int left);
		logic [31:0] seq;
		int          n;
		case ($urandom_range(0, 8))
			0: begin seq = 32'h00;          n = 1; end // NUL
			1: begin seq = 32'hAF_C0;       n = 2; end // overlong two-byte
			2: begin seq = 32'hAF_80_E0;    n = 3; end // overlong three-byte
			3: begin seq = 32'h80_A0_ED;    n = 3; end // surrogate
			4: begin seq = 32'h80_80_90_F4; n = 4; end // past the last plane
			5: begin seq = 32'hBF_BF_8F_F0; n = 4; end // overlong four-byte
			6: begin seq = 32'h80;          n = 1; end // stray continuation
			7: begin seq = 32'h41_C3;       n = 2; end // lead without continuation
			default: begin
				seq = 32'($urandom_range(8'hF5, 8'hFF));
				n   = 1;
			end
		endcase
		n = (n < left) ? n : left;
		put_le(seq, n);
		return n;
	endfunction

	function automatic void put_text(int len, bit spoil);
		int left;
		int size;
		left = len;
		while (left > 0) begin
			if (spoil && $urandom_range(0, 7) == 0) begin
				left -= put_bad_utf(left);
			end else begin
				size = $urandom_range(1, (left < 4) ? left : 4);
				put_char(size);
				left -= size;
			end
		end
	endfunction

	// Append header, value and zero padding of one record.
	function automatic void put_record(logic [15:0] rtype, logic [15:0] rflags,
			logic [31:0] rlen, bit spoil);
		put_le({rflags, rtype}, 4);
		put_le(rlen, 4);
		if (rtype == TLV_TYPE_TEXT || rtype == TLV_TYPE_NAME) begin
			put_text(int'(rlen), spoil);
		end else begin
			for (int i = 0; i < int'(rlen); i++) begin
				blob_bytes.push_back(8'($urandom));
			end
		end
		while (blob_bytes.size() % 8 != 0) begin
			blob_bytes.push_back(8'h00);
		end
	endfunction

	// Build a run of one to four records with rising types; with spoil set,
	// slip in bad types, flags, lengths and text now and then.
	function automatic void build_blob(bit spoil);
		int          prev;
		int          rtype;
		int          nrec;
		logic [15:0] rflags;
		logic [31:0] rlen;
		prev = 0;
		nrec = $urandom_range(1, 4);
		for (int r = 0; r < nrec && prev < 32'hFFFF; r++) begin
			if (prev < 4 && $urandom_range(0, 2) != 0) begin
				rtype = $urandom_range(prev + 1, 4);
			end else if ($urandom_range(0, 15) == 0) begin
				rtype = 32'hFFFF;
			end else begin
				rtype = prev + $urandom_range(1, 400);
			end
			if (rtype > 32'hFFFF) begin
				rtype = 32'hFFFF;
			end
			if (spoil && $urandom_range(0, 19) == 0) begin
				rtype = ($urandom_range(0, 1) != 0) ? prev : 0;
			end
			rflags = ($urandom_range(0, 2) == 0) ? 16'd1 : 16'd0;
			if (spoil && $urandom_range(0, 19) == 0) begin
				rflags = 16'($urandom);
			end
			case (rtype)
				TLV_TYPE_U32: rlen = LEN_U32;
				TLV_TYPE_U64: rlen = LEN_U64;
				TLV_TYPE_TEXT: begin
					case ($urandom_range(0, 39))
						0: rlen = LEN_TEXT_MAX;
						1: rlen = $urandom_range(1, LEN_TEXT_MAX);
						default: rlen = $urandom_range(1, 24);
					endcase
				end
				TLV_TYPE_NAME: begin
					rlen = ($urandom_range(0, 19) == 0) ? LEN_NAME_MAX : $urandom_range(1, 24);
				end
				default: rlen = $urandom_range(0, 20);
			endcase
			if (spoil && $urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1) != 0) begin
					rlen = 32'd0;
				end else if (rtype == TLV_TYPE_TEXT) begin
					rlen = LEN_TEXT_MAX + 32'd1;
				end else if (rtype == TLV_TYPE_NAME) begin
					rlen = LEN_NAME_MAX + 32'd1;
				end else begin
					rlen = $urandom_range(0, 12);
				end
			end
			put_record(16'(rtype), rflags, rlen, spoil);
			prev = rtype;
		end
	endfunction

	// Offer one byte after a random gap and hold it until the block takes it.
	task automatic send_item(logic [7:0] data, logic final_byte, logic [15:0] total);
		int gap;
		gap = calm_tx ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {total, data};
		s_tlast  <= final_byte;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Stream the assembled blob; the item at odd_at carries odd_total instead.
	task automatic send_blob(logic [15:0] total, int odd_at, logic [15:0] odd_total);
		for (int i = 0; i < blob_bytes.size(); i++) begin
			send_item(blob_bytes[i], i == blob_bytes.size() - 1,
				(i == odd_at) ? odd_total : total);
		end
	endtask

	// Receiver: draw a stall after every status transaction; hold_off
	// overrides it and keeps the output channel blocked.
	initial begin : receiver
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if ($urandom_range(0, 15) == 0) begin
					calm_rx = ~calm_rx;
				end
				stall = calm_rx ? 0 : $urandom_range(0, 11);
			end
			if (hold_off || stall != 0) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			if (!hold_off && stall != 0) begin
				stall--;
			end
		end
	end

	// Block the output channel for long stretches while bytes keep coming,
	// so that a second final byte backs up into the input channel.
	initial begin : back_pressure
		wait (items_sent >= 250);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (1500) @(posedge clk);
		hold_off <= 1'b0;
		wait (items_sent >= 900);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (1500) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin : stimulus
		int          kind;
		int          cut;
		int          odd_at;
		int          first_random;
		logic [15:0] total;
		logic [15:0] odd_total;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty blob: one transaction with zero length
		send_item(8'hFF, 1'b1, 16'd0);

		// Oversized declared length
		blob_bytes = '{8'h00, 8'hFF};
		send_blob(16'hFFFF, -1, 16'd0);

		// Short blob: final byte long before the declared length
		blob_bytes = '{8'h01};
		send_blob(16'd8, -1, 16'd0);

		// Empty record, then one byte past the declared length
		blob_bytes.delete();
		put_record(16'd5, 16'd0, 32'd0, 1'b0);
		blob_bytes.push_back(8'hFF);
		send_blob(16'd8, -1, 16'd0);

		// Critical record of an unknown type
		blob_bytes.delete();
		put_record(16'hFFFF, 16'd1, 32'd0, 1'b0);
		send_blob(16'd8, -1, 16'd0);

		first_random = items_sent;
		for (int blobs = 0; items_sent < first_random + RANDOM_ITEMS || blobs < MIN_BLOBS;
				blobs++) begin
			blob_bytes.delete();
			odd_at    = -1;
			odd_total = '0;
			kind      = $urandom_range(0, 99);
			if ($urandom_range(0, 7) == 0) begin
				calm_tx = ~calm_tx;
			end
			if (kind < 4) begin
				send_item(8'($urandom), 1'b1, 16'd0);
			end else if (kind < 10) begin
				// noise: random bytes under a random declared length
				repeat ($urandom_range(1, 40)) blob_bytes.push_back(8'($urandom));
				case ($urandom_range(0, 2))
					0: total = 16'(blob_bytes.size());
					1: total = 16'($urandom);
					default: total = 16'($urandom_range(0, 64));
				endcase
				send_blob(total, odd_at, odd_total);
			end else begin
				build_blob(kind >= 85);
				total = 16'(blob_bytes.size());
				if (kind >= 70) begin
					case ($urandom_range(0, 5))
						0: blob_bytes[$urandom_range(0, blob_bytes.size() - 1)] = 8'($urandom);
						1: begin
							// drop the tail; the declared length stays
							cut = $urandom_range(1, blob_bytes.size() - 1);
							repeat (cut) void'(blob_bytes.pop_back());
						end
						2: total = total + 16'($urandom_range(1, 16));
						3: total = total - 16'($urandom_range(1, 8));
						4: total = 16'($urandom_range(MAX_META_BYTES + 16'd1, 16'hFFFF));
						default: begin
							odd_at    = $urandom_range(0, blob_bytes.size() - 1);
							odd_total = 16'($urandom);
						end
					endcase
				end
				send_blob(total, odd_at, odd_total);
			end
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		// Drain: let the last status through, then watch for strays
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
